FILE: sv/bit_vector_shift_rotate_engine_assert.svh
// Assertion macros used by the bit vector engine controller RTL.
`ifndef BIT_VECTOR_SHIFT_ROTATE_ENGINE_ASSERT_SVH
`define BIT_VECTOR_SHIFT_ROTATE_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BVSRE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define BVSRE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/bvsre_pkg.sv
// Types and constants for the bit vector shift/rotate engine.
package bvsre_pkg;

  localparam int unsigned FUNC_W    = 4;
  localparam int unsigned INDEX_W   = 6;
  localparam int unsigned AMT_W     = 32;
  localparam int unsigned MOD_STEPS = 4;
  localparam int unsigned CNT_W     = $clog2(MOD_STEPS);

  localparam logic [FUNC_W-1:0] FUNC_GET    = 4'd0;
  localparam logic [FUNC_W-1:0] FUNC_SET    = 4'd1;
  localparam logic [FUNC_W-1:0] FUNC_TOGGLE = 4'd2;
  localparam logic [FUNC_W-1:0] FUNC_SWAP   = 4'd3;
  localparam logic [FUNC_W-1:0] FUNC_FILL   = 4'd4;
  localparam logic [FUNC_W-1:0] FUNC_SHL    = 4'd5;
  localparam logic [FUNC_W-1:0] FUNC_SHR    = 4'd6;
  localparam logic [FUNC_W-1:0] FUNC_ROTL   = 4'd7;
  localparam logic [FUNC_W-1:0] FUNC_ROTR   = 4'd8;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [INDEX_W-1:0] bit_index;
    logic [INDEX_W-1:0] second_index;
    logic               bit_value;
    logic [AMT_W-1:0]   shift_amount;
  } bvsre_req_t;

  typedef struct packed {
    logic read_bit;
    logic index_error;
  } bvsre_rsp_t;

  typedef struct packed {
    logic load;      // latch a new transaction
    logic mod_step;  // advance the rotate-amount reduction pipeline
    logic exec;      // update vector and result registers
  } bvsre_cmd_t;

  typedef struct packed {
    logic rot_in;    // incoming transaction is a rotate
  } bvsre_sts_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOD,
    ST_EXEC
  } bvsre_state_e;

endpackage

FILE: sv/bvsre_ctrl.sv
// Controller FSM: sequences load, remainder iterations and execute.
`include "bit_vector_shift_rotate_engine_assert.svh"

module bvsre_ctrl
  import bvsre_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  bvsre_sts_t sts_i,
  output bvsre_cmd_t cmd_o,
  output logic       busy,
  output logic       valid_o
);

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MOD_STEPS - 1);

  bvsre_state_e     state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             valid_q, valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      valid_q <= valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    valid_d = 1'b0;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = sts_i.rot_in ? ST_MOD : ST_EXEC;
        end
      end
      ST_MOD: begin
        cmd_o.mod_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        valid_d    = 1'b1;
        state_d    = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy    = (state_q != ST_IDLE);
  assign valid_o = valid_q;

  `BVSRE_ASSERT_NEXT(a_exec_gives_result, clk_i, rst_ni,
                     state_q == ST_EXEC, valid_q, "execute without result strobe")
  `BVSRE_ASSERT_IMPL(a_result_when_idle, clk_i, rst_ni,
                     valid_q, state_q == ST_IDLE, "result strobe while busy")
  `BVSRE_ASSERT_NEXT(a_accept_goes_busy, clk_i, rst_ni,
                     start && !busy, busy, "accepted transaction did not raise busy")
  `BVSRE_ASSERT_IMPL(a_mod_only_in_mod, clk_i, rst_ni,
                     cmd_o.mod_step, !cmd_o.exec && !cmd_o.load, "conflicting datapath commands")

endmodule

FILE: sv/bvsre_datapath.sv
// Datapath: vector register, rotate-amount remainder unit, shifter and result register.
module bvsre_datapath
  import bvsre_pkg::*;
#(
  parameter int unsigned VECTOR_BITS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  bvsre_req_t item_i,
  input  bvsre_cmd_t cmd_i,
  output bvsre_sts_t sts_o,
  output bvsre_rsp_t result_o
);

  localparam int unsigned IW      = $clog2(VECTOR_BITS);
  localparam int unsigned CHUNK_W = 8;
  localparam int unsigned CHUNKS  = AMT_W / CHUNK_W;
  localparam int unsigned PW      = $clog2(CHUNK_W * VECTOR_BITS);
  localparam int unsigned SW      = PW + $clog2(CHUNKS);
  localparam logic [INDEX_W:0]  NB_IDX = (INDEX_W + 1)'(VECTOR_BITS);
  localparam logic [AMT_W-1:0]  NB_AMT = AMT_W'(VECTOR_BITS);
  localparam logic [SW-1:0]     RED_16N = SW'(16 * VECTOR_BITS);
  localparam logic [SW-1:0]     RED_8N  = SW'(8 * VECTOR_BITS);
  localparam logic [SW-1:0]     RED_4N  = SW'(4 * VECTOR_BITS);
  localparam logic [SW-1:0]     RED_2N  = SW'(2 * VECTOR_BITS);
  localparam logic [SW-1:0]     RED_1N  = SW'(VECTOR_BITS);
  localparam logic [VECTOR_BITS-1:0] ONE  = {{(VECTOR_BITS-1){1'b0}}, 1'b1};
  localparam logic [VECTOR_BITS-1:0] ONES = '1;

  // 2^pos mod VECTOR_BITS by repeated doubling; elaboration only.
  function automatic int unsigned pow2_mod(input int pos);
    int unsigned r;
    r = 1;
    for (int i = 0; i < pos; i++) begin
      r = r << 1;
      if (r >= VECTOR_BITS) begin
        r = r - VECTOR_BITS;
      end
    end
    return r;
  endfunction

  bvsre_req_t             item_q;
  logic [VECTOR_BITS-1:0] vec_q, vec_d;
  logic [PW-1:0]          psum_q [CHUNKS];
  logic [PW-1:0]          psum_d [CHUNKS];
  logic [SW-1:0]          tot_q, tot_d;
  logic [SW-1:0]          red_q, red_d;
  logic [IW-1:0]          rem_q, rem_d;
  bvsre_rsp_t             rsp_q, rsp_d;

  logic [IW-1:0]            term [AMT_W];
  logic [SW-1:0]            red_a, red_b, red_c, rem_w;
  logic                     ok_a, ok_b, bit_a, bit_b;
  logic [IW-1:0]            ia, ib, sa, rr;
  logic [VECTOR_BITS-1:0]   ma, mb, shl_v, shr_v, fill_v;
  logic [2*VECTOR_BITS-1:0] dbl, rotl_w, rotr_w;
  logic                     big_shift;

  assign sts_o.rot_in = (item_i.func == FUNC_ROTL) || (item_i.func == FUNC_ROTR);

  // Rotate amount mod width: each set amount bit adds its residue of 2^i,
  // summed per byte, then totaled, then brought below the width by
  // compare and subtract. One pipeline step per mod_step, MOD_STEPS deep.
  for (genvar g = 0; g < AMT_W; g++) begin : g_res
    localparam logic [IW-1:0] RES = IW'(pow2_mod(g));
    assign term[g] = item_q.shift_amount[g] ? RES : '0;
  end

  always_comb begin
    for (int unsigned k = 0; k < CHUNKS; k++) begin
      psum_d[k] = '0;
      for (int unsigned j = 0; j < CHUNK_W; j++) begin
        psum_d[k] = psum_d[k] + PW'(term[k*CHUNK_W + j]);
      end
    end
  end

  always_comb begin
    tot_d = '0;
    for (int unsigned k = 0; k < CHUNKS; k++) begin
      tot_d = tot_d + SW'(psum_q[k]);
    end
  end

  // Total is below 32 times the width.
  assign red_a = (tot_q >= RED_16N) ? (tot_q - RED_16N) : tot_q;
  assign red_b = (red_a >= RED_8N) ? (red_a - RED_8N) : red_a;
  assign red_d = (red_b >= RED_4N) ? (red_b - RED_4N) : red_b;
  assign red_c = (red_q >= RED_2N) ? (red_q - RED_2N) : red_q;
  assign rem_w = (red_c >= RED_1N) ? (red_c - RED_1N) : red_c;
  assign rem_d = rem_w[IW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= item_i;
    end
    if (cmd_i.mod_step) begin
      psum_q <= psum_d;
      tot_q  <= tot_d;
      red_q  <= red_d;
      rem_q  <= rem_d;
    end
    if (cmd_i.exec) begin
      rsp_q <= rsp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vec_q <= '0;
    end else if (cmd_i.exec) begin
      vec_q <= vec_d;
    end
  end

  assign ok_a  = {1'b0, item_q.bit_index} < NB_IDX;
  assign ok_b  = {1'b0, item_q.second_index} < NB_IDX;
  assign ia    = item_q.bit_index[IW-1:0];
  assign ib    = item_q.second_index[IW-1:0];
  assign bit_a = ok_a ? vec_q[ia] : 1'b0;
  assign bit_b = ok_b ? vec_q[ib] : 1'b0;
  assign ma    = ONE << ia;
  assign mb    = ONE << ib;

  assign big_shift = item_q.shift_amount >= NB_AMT;
  assign sa        = item_q.shift_amount[IW-1:0];
  assign fill_v    = item_q.bit_value ? ONES : '0;
  assign shl_v     = (vec_q << sa) | (item_q.bit_value ? ~(ONES << sa) : '0);
  assign shr_v     = (vec_q >> sa) | (item_q.bit_value ? ~(ONES >> sa) : '0);

  // Remainder is below the width, so it fits the index width.
  assign rr     = rem_q;
  assign dbl    = {vec_q, vec_q};
  assign rotl_w = dbl << rr;
  assign rotr_w = dbl >> rr;

  always_comb begin
    vec_d             = vec_q;
    rsp_d.read_bit    = bit_a;
    rsp_d.index_error = 1'b0;
    case (item_q.func)
      FUNC_GET: begin
        rsp_d.index_error = !ok_a;
      end
      FUNC_SET: begin
        rsp_d.index_error = !ok_a;
        if (ok_a) begin
          vec_d = item_q.bit_value ? (vec_q | ma) : (vec_q & ~ma);
        end
      end
      FUNC_TOGGLE: begin
        rsp_d.index_error = !ok_a;
        if (ok_a) begin
          vec_d = vec_q ^ ma;
        end
      end
      FUNC_SWAP: begin
        rsp_d.index_error = !(ok_a && ok_b);
        if (ok_a && ok_b) begin
          vec_d = (vec_q & ~(ma | mb)) | (bit_b ? ma : '0) | (bit_a ? mb : '0);
        end
      end
      FUNC_FILL: begin
        vec_d = fill_v;
      end
      FUNC_SHL: begin
        vec_d = big_shift ? fill_v : shl_v;
      end
      FUNC_SHR: begin
        vec_d = big_shift ? fill_v : shr_v;
      end
      FUNC_ROTL: begin
        vec_d = rotl_w[2*VECTOR_BITS-1:VECTOR_BITS];
      end
      FUNC_ROTR: begin
        vec_d = rotr_w[VECTOR_BITS-1:0];
      end
      default: begin
        vec_d = vec_q;
      end
    endcase
  end

  assign result_o = rsp_q;

endmodule

FILE: sv/bit_vector_shift_rotate_engine.sv
// Top level of the bit vector shift/rotate engine.
//
// Holds a VECTOR_BITS-wide bit vector, all zeros after reset.
// Command channel: a transaction is taken at a rising edge with start high
// and busy low; item_i carries func, indices, fill bit and shift amount.
// Result channel: valid_o is high for exactly one cycle with result_o
// (read_bit, index_error); the receiver has no way to stall it.
// After acceptance, get, set, toggle, swap, fill and shifts go straight to the
// execute state; rotates first have their amount reduced modulo VECTOR_BITS
// in a four-step pipeline (per-bit residues summed, then compare and
// subtract) run while busy is held. The result is registered at execute.
// busy drops in the cycle the result is shown, so the next transaction may
// be accepted at the edge that ends it; one transaction is handled at a time.
// Reset (rst_ni low, asynchronous) clears the vector and the controller;
// no result is pending afterwards.
module bit_vector_shift_rotate_engine
  import bvsre_pkg::*;
#(
  parameter int unsigned VECTOR_BITS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  bvsre_req_t item_i,
  output logic       busy,
  output logic       valid_o,
  output bvsre_rsp_t result_o
);

  bvsre_cmd_t cmd;
  bvsre_sts_t sts;

  bvsre_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy    (busy),
    .valid_o (valid_o)
  );

  bvsre_datapath #(
    .VECTOR_BITS (VECTOR_BITS)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_i),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .result_o (result_o)
  );

endmodule
